@@ design/swrf_pkg.sv @@
// Shared types, constants and saturating helpers for the shallow-water Rusanov flux core.
package swrf_pkg;

	localparam int IW     = 62;   // inner value width, holds +-(2^61 - 1)
	localparam int AW     = 33;   // narrow multiplier operand width
	localparam int IN_W   = 32;
	localparam int OUT_W  = 48;
	localparam int MUL_LAT = 3;

	typedef logic signed [IW-1:0]    inner_t;
	typedef logic signed [AW-1:0]    narrow_t;
	typedef logic signed [OUT_W-1:0] flux_t;

	localparam inner_t INNER_LIM = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW:0] SUM_MAX = {2'b00, {(IW-1){1'b1}}};
	localparam logic signed [IW:0] SUM_MIN = -SUM_MAX;
	localparam inner_t OUT_MAX_I = inner_t'({1'b0, {(OUT_W-1){1'b1}}});
	localparam inner_t OUT_MIN_I = -OUT_MAX_I - inner_t'(1);

	function automatic inner_t clamp_sum(logic signed [IW:0] s);
		inner_t r;
		if (s > SUM_MAX) begin
			r = INNER_LIM;
		end else if (s < SUM_MIN) begin
			r = -INNER_LIM;
		end else begin
			r = s[IW-1:0];
		end
		return r;
	endfunction

	function automatic inner_t sat_add(inner_t a, inner_t b);
		logic signed [IW:0] s;
		s = {a[IW-1], a} + {b[IW-1], b};
		return clamp_sum(s);
	endfunction

	function automatic inner_t sat_sub(inner_t a, inner_t b);
		logic signed [IW:0] s;
		s = {a[IW-1], a} - {b[IW-1], b};
		return clamp_sum(s);
	endfunction

	// halve, rounding toward zero
	function automatic inner_t half_tz(inner_t a);
		inner_t t;
		t = a + inner_t'({{(IW-1){1'b0}}, a[IW-1]});
		return t >>> 1;
	endfunction

	function automatic flux_t to_flux(inner_t a);
		flux_t r;
		if (a > OUT_MAX_I) begin
			r = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (a < OUT_MIN_I) begin
			r = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			r = a[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ design/swrf_dly.sv @@
// Enabled shift-register delay line for pipeline side data.
module swrf_dly #(
	parameter int W     = 32,
	parameter int DEPTH = 3
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] sr_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign q = sr_q[DEPTH-1];
endmodule

@@ design/swrf_mul.sv @@
// Three-stage signed fixed-point multiply with truncating shift and saturation.
module swrf_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            en,
	input  swrf_pkg::narrow_t a,
	input  swrf_pkg::inner_t  b,
	output swrf_pkg::inner_t  p
);
	import swrf_pkg::*;

	localparam int BLO = 31;
	localparam int BHI = IW - 1 - BLO;
	localparam int FW  = AW + IW - 1;

	logic [AW-1:0]     amag;
	logic [IW-1:0]     bmag;
	logic [AW+BLO-1:0] plo_s1;
	logic [AW+BHI-1:0] phi_s1;
	logic              neg_s1;
	logic [FW-1:0]     full;
	logic [FW-1:0]     shr;
	logic [IW-2:0]     mag_s2;
	logic              neg_s2;
	inner_t            p_s3;

	assign amag = a[AW-1] ? AW'(-a) : AW'(a);
	assign bmag = b[IW-1] ? IW'(-b) : IW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= amag * bmag[BLO-1:0];
			phi_s1 <= amag * bmag[IW-2:BLO];
			neg_s1 <= a[AW-1] ^ b[IW-1];
		end
	end

	assign full = FW'(plo_s1) + {phi_s1, {BLO{1'b0}}};
	assign shr  = full >> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= (|shr[FW-1:IW-1]) ? {(IW-1){1'b1}} : shr[IW-2:0];
			neg_s2 <= neg_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3 <= neg_s2 ? -inner_t'({1'b0, mag_s2}) : inner_t'({1'b0, mag_s2});
		end
	end

	assign p = p_s3;
endmodule

@@ design/swrf_sqrt.sv @@
// Pipelined restoring integer square root, one root bit per stage.
module swrf_sqrt #(
	parameter int RADW  = 52,
	parameter int ROOTW = 26
) (
	input  logic             clk,
	input  logic             en,
	input  logic [RADW-1:0]  rad,
	output logic [ROOTW-1:0] root
);
	logic [RADW-1:0]  x_s [ROOTW];
	logic [ROOTW:0]   r_s [ROOTW];
	logic [ROOTW-1:0] q_s [ROOTW];

	for (genvar i = 0; i < ROOTW; i++) begin : g_stage
		logic [RADW-1:0]  x_in;
		logic [ROOTW:0]   r_in;
		logic [ROOTW-1:0] q_in;
		logic [ROOTW+2:0] rsh;
		logic [ROOTW+2:0] trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign x_in = rad;
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign r_in = r_s[i-1];
			assign q_in = q_s[i-1];
		end

		assign rsh   = {r_in, x_in[RADW-1:RADW-2]};
		assign trial = {1'b0, q_in, 2'b01};
		assign ge    = rsh >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i] <= x_in << 2;
				r_s[i] <= ge ? (ROOTW+1)'(rsh - trial) : rsh[ROOTW:0];
				q_s[i] <= {q_in[ROOTW-2:0], ge};
			end
		end
	end

	assign root = q_s[ROOTW-1];
endmodule

@@ design/shallow_water_rusanov_flux_core.sv @@
// Top level: streaming Rusanov flux pipeline for the 2-D shallow-water equations.
//
// channel  | dir | fields (low bit first)
// s_axis   | in  | depth_left, depth_right, normal_vel_left, normal_vel_right,
//          |     | tangent_vel_left, tangent_vel_right (32 bits each)
// m_axis   | out | mass_flux, normal_momentum_flux, tangent_momentum_flux (48 bits each)
//
// One interface per cycle sustained while s_axis_tready is high; the pipeline depth to the
// output register is set by the bit-per-stage square root in series with two multiplies.
// arst_n clears all valid bits; payload registers are not reset.
// A stalled output parks one result in a skid register; s_axis_tready is registered.
module shallow_water_rusanov_flux_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // depth_left, depth_right, normal_vel_left,
	                                    // normal_vel_right, tangent_vel_left, tangent_vel_right
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata   // mass_flux, normal_momentum_flux, tangent_momentum_flux
);
	import swrf_pkg::*;

	localparam int  RADW  = 2 * ((35 + FRAC_BITS + 1) / 2);
	localparam int  ROOTW = RADW / 2;
	localparam int  GHW   = RADW - FRAC_BITS;
	localparam int  T_CD  = MUL_LAT + ROOTW + 2;
	localparam int  LAST  = T_CD + MUL_LAT + 1;
	localparam longint G_Q  = ((longint'(981) << FRAC_BITS) + 50) / 100;
	localparam longint GH_Q = ((longint'(4905) << FRAC_BITS) + 500) / 1000;

	logic en;
	assign en = s_axis_tready;

	// input fields
	logic signed [IN_W-1:0] hl, hr, ul, ur, vl, vr;
	assign hl = s_axis_tdata[31:0];
	assign hr = s_axis_tdata[63:32];
	assign ul = s_axis_tdata[95:64];
	assign ur = s_axis_tdata[127:96];
	assign vl = s_axis_tdata[159:128];
	assign vr = s_axis_tdata[191:160];

	logic dry;
	assign dry = (hl[IN_W-1] || hl == '0) && (hr[IN_W-1] || hr == '0);

	inner_t hp_l, hp_r;
	assign hp_l = hl[IN_W-1] ? '0 : inner_t'(hl);
	assign hp_r = hr[IN_W-1] ? '0 : inner_t'(hr);

	// first multiply rank
	inner_t ql, qr, ghl, ghr, bl, br, hvl, hvr;
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mq_l (.clk, .en, .a(narrow_t'(ul)), .b(inner_t'(hl)), .p(ql));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mq_r (.clk, .en, .a(narrow_t'(ur)), .b(inner_t'(hr)), .p(qr));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mg_l (.clk, .en, .a(narrow_t'(G_Q)), .b(hp_l), .p(ghl));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mg_r (.clk, .en, .a(narrow_t'(G_Q)), .b(hp_r), .p(ghr));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mb_l (.clk, .en, .a(narrow_t'(GH_Q)), .b(inner_t'(hl)), .p(bl));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mb_r (.clk, .en, .a(narrow_t'(GH_Q)), .b(inner_t'(hr)), .p(br));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mv_l (.clk, .en, .a(narrow_t'(vl)), .b(inner_t'(hl)), .p(hvl));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mv_r (.clk, .en, .a(narrow_t'(vr)), .b(inner_t'(hr)), .p(hvr));

	logic [191:0] in_d3;
	swrf_dly #(.W(192), .DEPTH(MUL_LAT)) u_dly_in (.clk, .en, .d(s_axis_tdata), .q(in_d3));

	logic signed [IN_W-1:0] hl3, hr3, ul3, ur3, vl3, vr3;
	assign hl3 = in_d3[31:0];
	assign hr3 = in_d3[63:32];
	assign ul3 = in_d3[95:64];
	assign ur3 = in_d3[127:96];
	assign vl3 = in_d3[159:128];
	assign vr3 = in_d3[191:160];

	// second multiply rank
	inner_t pa_l, pa_r, pb_l, pb_r, pe_l, pe_r;
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_ma_l (.clk, .en, .a(narrow_t'(ul3)), .b(ql), .p(pa_l));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_ma_r (.clk, .en, .a(narrow_t'(ur3)), .b(qr), .p(pa_r));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mh_l (.clk, .en, .a(narrow_t'(hl3)), .b(bl), .p(pb_l));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mh_r (.clk, .en, .a(narrow_t'(hr3)), .b(br), .p(pb_r));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_me_l (.clk, .en, .a(narrow_t'(vl3)), .b(ql), .p(pe_l));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_me_r (.clk, .en, .a(narrow_t'(vr3)), .b(qr), .p(pe_r));

	// jumps and centered mass flux
	inner_t qs_s4, dh_s4, dq_s4, dhv_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			qs_s4  <= half_tz(sat_add(ql, qr));
			dh_s4  <= sat_sub(inner_t'(hr3), inner_t'(hl3));
			dq_s4  <= sat_sub(qr, ql);
			dhv_s4 <= sat_sub(hvr, hvl);
		end
	end

	// momentum sums, in the fixed order that saturation depends on
	inner_t m1_s7, c_s7, d_s7, t3_s7, m2_s8, d_s8, m3_s9, mh_s10;
	always_ff @(posedge clk) begin
		if (en) begin
			m1_s7  <= sat_add(pa_l, pb_l);
			c_s7   <= pa_r;
			d_s7   <= pb_r;
			t3_s7  <= half_tz(sat_add(pe_l, pe_r));
			m2_s8  <= sat_add(m1_s7, c_s7);
			d_s8   <= d_s7;
			m3_s9  <= sat_add(m2_s8, d_s8);
			mh_s10 <= half_tz(m3_s9);
		end
	end

	// celerity roots
	logic [ROOTW-1:0] cel_l, cel_r;
	swrf_sqrt #(.RADW(RADW), .ROOTW(ROOTW)) u_sqrt_l (
		.clk, .en, .rad({ghl[GHW-1:0], {FRAC_BITS{1'b0}}}), .root(cel_l));
	swrf_sqrt #(.RADW(RADW), .ROOTW(ROOTW)) u_sqrt_r (
		.clk, .en, .rad({ghr[GHW-1:0], {FRAC_BITS{1'b0}}}), .root(cel_r));

	logic [2*IN_W-1:0] u_dr;
	swrf_dly #(.W(2*IN_W), .DEPTH(ROOTW)) u_dly_u (.clk, .en, .d({ur3, ul3}), .q(u_dr));

	logic signed [IN_W-1:0] ul_r, ur_r;
	logic [IN_W-1:0]        ulm, urm;
	assign ul_r = u_dr[IN_W-1:0];
	assign ur_r = u_dr[2*IN_W-1:IN_W];
	assign ulm  = ul_r[IN_W-1] ? IN_W'(-ul_r) : IN_W'(ul_r);
	assign urm  = ur_r[IN_W-1] ? IN_W'(-ur_r) : IN_W'(ur_r);

	logic [IN_W:0]   spd_l_sc1, spd_r_sc1;
	logic [IN_W-1:0] cd_sc2;
	always_ff @(posedge clk) begin
		if (en) begin
			spd_l_sc1 <= (IN_W+1)'(ulm) + (IN_W+1)'(cel_l);
			spd_r_sc1 <= (IN_W+1)'(urm) + (IN_W+1)'(cel_r);
			cd_sc2    <= (spd_l_sc1 >= spd_r_sc1) ? spd_l_sc1[IN_W:1] : spd_r_sc1[IN_W:1];
		end
	end

	// align jumps with the half wave speed
	logic [3*IW-1:0] jump_d;
	swrf_dly #(.W(3*IW), .DEPTH(T_CD - 4)) u_dly_jump (
		.clk, .en, .d({dhv_s4, dq_s4, dh_s4}), .q(jump_d));

	inner_t pc_h, pc_q, pc_v;
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mc_h (.clk, .en, .a({1'b0, cd_sc2}),
		.b(jump_d[IW-1:0]), .p(pc_h));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mc_q (.clk, .en, .a({1'b0, cd_sc2}),
		.b(jump_d[2*IW-1:IW]), .p(pc_q));
	swrf_mul #(.FRAC_BITS(FRAC_BITS)) u_mc_v (.clk, .en, .a({1'b0, cd_sc2}),
		.b(jump_d[3*IW-1:2*IW]), .p(pc_v));

	// align centered fluxes and the dry flag with the diffusion products
	inner_t qs_f, mh_f, t3_f;
	logic   dry_f;
	swrf_dly #(.W(IW), .DEPTH(T_CD - 1)) u_dly_qs (.clk, .en, .d(qs_s4), .q(qs_f));
	swrf_dly #(.W(IW), .DEPTH(T_CD - 7)) u_dly_mh (.clk, .en, .d(mh_s10), .q(mh_f));
	swrf_dly #(.W(IW), .DEPTH(T_CD - 4)) u_dly_t3 (.clk, .en, .d(t3_s7), .q(t3_f));
	swrf_dly #(.W(1), .DEPTH(T_CD + MUL_LAT)) u_dly_dry (.clk, .en, .d(dry), .q(dry_f));

	logic [143:0] flux_so;
	always_ff @(posedge clk) begin
		if (en) begin
			if (dry_f) begin
				flux_so <= '0;
			end else begin
				flux_so <= {to_flux(sat_sub(t3_f, pc_v)), to_flux(sat_sub(mh_f, pc_q)),
				            to_flux(sat_sub(qs_f, pc_h))};
			end
		end
	end

	// valid bits travel with the data
	logic [LAST-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-2:0], s_axis_tvalid};
		end
	end

	logic push;
	assign push = en && vld_q[LAST-1];

	// output register with one skid slot
	logic         out_valid_q, skid_valid_q;
	logic [143:0] out_data_q, skid_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : flux_so;
		end else if (push) begin
			skid_data_q <= flux_so;
		end
	end

	assign s_axis_tready = !skid_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds a result while the output register is empty");

	a_stall_parks_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready && push) |=> skid_valid_q)
		else $error("result pushed into a stalled output was dropped");

	a_skid_drains_first: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && m_axis_tready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid slot did not move to the output on transfer");

	a_dry_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && dry_f) |=> (flux_so == '0))
		else $error("dry interface produced a nonzero flux");
`endif
endmodule
